@@ rtl/integer_set_table_core_assert.svh @@
// assertion macros used by the checker file
`ifndef INTEGER_SET_TABLE_CORE_ASSERT_SVH
`define INTEGER_SET_TABLE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define IST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the integer set table.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int CFG_W           = 5;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;

    // register word index on the config port
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        OP_HAS    = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } ist_op_t;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // per-cell control from the table core
    typedef struct packed {
        logic valid;
        logic load;
        logic shift;
    } ist_cell_ctrl_t;

endpackage

@@ rtl/ist_cell.sv @@
// ----------------------------------------------------------------------------
// ist_cell
// One slot of the set: holds an entry, matches it against the key, and takes
// the key on insert or its upper neighbor's entry on remove.
// ----------------------------------------------------------------------------
module ist_cell
(
    input  logic                              clk,
    input  ist_pkg::ist_cell_ctrl_t           ctrl,
    input  logic signed [ist_pkg::VALUE_W-1:0] key,
    input  logic signed [ist_pkg::VALUE_W-1:0] upper_entry,
    input  logic                              match_in,
    output logic signed [ist_pkg::VALUE_W-1:0] entry,
    output logic                              match_out
);
    import ist_pkg::*;

    logic signed [VALUE_W-1:0] entry_reg;
    logic                      hit;

    assign hit       = ctrl.valid && (entry_reg == key);
    // a match here or below means this slot closes the gap
    assign match_out = match_in || hit;
    assign entry     = entry_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= key;
        end
        else if (ctrl.shift && match_out)
        begin
            entry_reg <= upper_entry;
        end
    end

endmodule

@@ rtl/integer_set_table_core.sv @@
// ----------------------------------------------------------------------------
// integer_set_table_core
// Set of distinct 32-bit values held in a row of cells, with query, insert
// and remove, and an APB register for the capacity limit.
// ----------------------------------------------------------------------------
// stages: input register, then execute, which registers the result on m_tdata
// throughput: one item per cycle while m_tready stays high; the compare and
//   match chain across all cells settles combinationally in the execute stage
// reset: rst_n clears the count, the pipeline valids and sets capacity to 16;
//   cell contents are not cleared, slots at or above the count are ignored
module integer_set_table_core
#(
    parameter int MAX_ENTRIES = ist_pkg::MAX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] found, [1] status, [6:2] count,
                                   // [7] is_empty, [8] is_full
);
    import ist_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]          cap_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      a_valid_reg;
    logic [1:0]                a_op_reg;
    logic signed [VALUE_W-1:0] a_value_reg;
    logic                      out_valid_reg;
    logic [8:0]                out_data_reg, out_data_next;

    logic                      exec;
    logic                      found;
    logic                      status;
    logic                      ins_ok;
    logic [LIM_W-1:0]          lim;
    logic [LIM_W-1:0]          cap_ext;

    logic signed [VALUE_W-1:0] cell_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES:0]      match_chain;

    // config port
    assign pready = 1'b1;
    assign prdata = {{(32-CFG_W){1'b0}}, cap_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CFG_W-1:0];
        end
    end

    // effective limit saturates at the row length
    assign cap_ext = LIM_W'(cap_reg);
    assign lim     = (cap_ext > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES) : cap_ext;

    // input stage
    assign exec     = a_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            a_op_reg    <= s_tuser;
            a_value_reg <= s_tdata;
        end
    end

    // row of cells
    assign match_chain[0] = 1'b0;
    assign found          = match_chain[MAX_ENTRIES];
    assign ins_ok         = (a_op_reg == OP_INSERT) && !found
                            && (LIM_W'(count_reg) < lim);

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        ist_cell_ctrl_t            ctrl;
        logic signed [VALUE_W-1:0] upper;

        assign ctrl.valid = CNT_W'(i) < count_reg;
        assign ctrl.load  = exec && ins_ok && (count_reg == CNT_W'(i));
        assign ctrl.shift = exec && (a_op_reg == OP_REMOVE);

        if (i == MAX_ENTRIES - 1)
        begin : g_top
            assign upper = cell_entry[i];
        end
        else
        begin : g_mid
            assign upper = cell_entry[i+1];
        end

        ist_cell u_cell
        (
            .clk         (clk),
            .ctrl        (ctrl),
            .key         (a_value_reg),
            .upper_entry (upper),
            .match_in    (match_chain[i]),
            .entry       (cell_entry[i]),
            .match_out   (match_chain[i+1])
        );
    end

    // count update and result
    always_comb
    begin
        count_next = count_reg;
        status     = ST_DONE;
        case (a_op_reg)
            OP_INSERT:
            begin
                if (!found)
                begin
                    if (ins_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status = ST_FULL;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        out_data_next[0]   = found;
        out_data_next[1]   = status;
        out_data_next[6:2] = COUNT_OUT_W'(count_next);
        out_data_next[7]   = (count_next == '0);
        out_data_next[8]   = (LIM_W'(count_next) >= lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

endmodule

@@ rtl/ist_checker.sv @@
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks of the integer set table, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_set_table_core_assert.svh"

module ist_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result holds
    `IST_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // a rejected insert means the value was absent and the set is full
    `IST_ASSERT_NOW(a_reject, m_tvalid && m_tdata[1], !m_tdata[0] && m_tdata[8], "reject without full set")

    // empty flag only with a zero count
    `IST_ASSERT_NOW(a_empty, m_tvalid && m_tdata[7], m_tdata[6:2] == 5'd0, "empty with nonzero count")

    // padding bits stay clear
    `IST_ASSERT_NOW(a_pad, m_tvalid, m_tdata[15:9] == 7'd0, "padding bits set")

endmodule

bind integer_set_table_core ist_checker u_ist_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the integer set table: query, insert and remove transactions
// go in on the input stream, each response is checked field by field against
// a queue-based model of the set, under several capacity limits.
// ----------------------------------------------------------------------------
module tb;
    import ist_pkg::*;

    // opcode with no operation of its own, behaves as a query
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] CAP_ADDR  = 3'(REG_CAPACITY) << 2;

    // response word, last field in the lowest bit
    typedef struct packed {
        logic       is_full;
        logic       is_empty;
        logic [4:0] count;
        logic       status;
        logic       found;
    } set_resp_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // model of the set and its limit
    logic [31:0] members[$];
    logic [4:0]  cap_limit;
    set_resp_t   pending_resp[$];
    int unsigned mismatches = 0;
    bit          bubbles_on;
    logic [31:0] value_pool[24];

    integer_set_table_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= !bubbles_on || ($urandom_range(99) >= 16);
    end

    function automatic set_resp_t apply_op(input logic [1:0] op, input logic [31:0] val);
        set_resp_t   r;
        int          slot;
        int unsigned lim;
        lim  = (cap_limit > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : cap_limit;
        slot = -1;
        foreach (members[i])
            if (slot < 0 && members[i] == val)
                slot = i;
        r.found  = (slot >= 0);
        r.status = ST_DONE;
        if (op == OP_INSERT && slot < 0)
        begin
            if (members.size() >= lim)
                r.status = ST_FULL;
            else
                members.push_back(val);
        end
        else if (op == OP_REMOVE && slot >= 0)
        begin
            // later entries close the gap
            members.delete(slot);
        end
        r.count    = 5'(members.size());
        r.is_empty = (members.size() == 0);
        r.is_full  = (members.size() >= lim);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // response checker
    always @(posedge clk)
    begin
        set_resp_t got;
        set_resp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = set_resp_t'(m_tdata[8:0]);
            if (pending_resp.size() == 0)
            begin
                $error("response transaction with none outstanding: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_resp.pop_front();
                check_field("found",    32'(want.found),    32'(got.found));
                check_field("status",   32'(want.status),   32'(got.status));
                check_field("count",    32'(want.count),    32'(got.count));
                check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                check_field("is_full",  32'(want.is_full),  32'(got.is_full));
            end
        end
    end

    task automatic send_op(input logic [1:0] op, input logic [31:0] val);
        while (bubbles_on && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_resp.push_back(apply_op(op, val));
    endtask

    // wait for all responses, then let the pipeline empty
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] lim);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {27'd0, lim};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cap_limit = lim;
    endtask

    task automatic test_empty_set;
        send_op(OP_HAS, 32'd0);
        send_op(OP_REMOVE, 32'd5);
        send_op(OP_UNUSED, 32'd7);
        drain();
    endtask

    task automatic test_basic_ops;
        send_op(OP_INSERT, 32'h8000_0000);
        send_op(OP_INSERT, 32'h7fff_ffff);
        send_op(OP_INSERT, 32'h0000_0000);
        send_op(OP_INSERT, 32'hffff_ffff);
        send_op(OP_INSERT, 32'h7fff_ffff);   // already present
        send_op(OP_HAS, 32'h0000_0000);
        send_op(OP_HAS, 32'h0000_0001);
        send_op(OP_REMOVE, 32'h0000_0000);   // middle entry, tail shifts down
        send_op(OP_HAS, 32'hffff_ffff);
        send_op(OP_UNUSED, 32'h8000_0000);
        send_op(OP_REMOVE, 32'h0001_2345);
        drain();
    endtask

    task automatic test_capacity_edges;
        write_capacity(5'd3);
        send_op(OP_INSERT, 32'd42);          // set already holds three
        drain();
        write_capacity(5'd1);                // limit below the count
        send_op(OP_INSERT, 32'd43);
        send_op(OP_REMOVE, 32'h7fff_ffff);
        drain();
        write_capacity(5'd0);
        send_op(OP_REMOVE, 32'h8000_0000);
        send_op(OP_REMOVE, 32'hffff_ffff);
        send_op(OP_INSERT, 32'd5);           // empty and full at once
        drain();
    endtask

    task automatic test_random_traffic;
        logic [4:0]  phase_lim[7];
        logic [1:0]  op;
        logic [31:0] val;
        int unsigned pick;
        phase_lim = '{5'd31, 5'd16, 5'd1, 5'd17, 5'(4 + $urandom_range(10)), 5'd0,
                      5'($urandom_range(31))};
        foreach (phase_lim[p])
        begin
            foreach (value_pool[i])
                value_pool[i] = $urandom();
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7fff_ffff;
            value_pool[2] = 32'h0000_0000;
            value_pool[3] = 32'hffff_ffff;
            write_capacity(phase_lim[p]);
            // one phase runs with no bubbles on either side
            bubbles_on = (p != 1);
            repeat (250)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    op = OP_INSERT;
                else if (pick < 70)
                    op = OP_REMOVE;
                else if (pick < 92)
                    op = OP_HAS;
                else
                    op = OP_UNUSED;
                if ($urandom_range(99) < 80)
                    val = value_pool[$urandom_range(23)];
                else
                    val = $urandom();
                send_op(op, val);
            end
            drain();
            bubbles_on = 1'b1;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cap_limit  = CAPACITY_RESET;
        bubbles_on = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_set();
        test_basic_ops();
        test_capacity_edges();
        test_random_traffic();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ integer_set_table_core.f @@
+incdir+rtl
rtl/ist_pkg.sv
rtl/ist_cell.sv
rtl/integer_set_table_core.sv
rtl/ist_checker.sv
test/tb.sv
